// ===== rtl/qrs_pkg.sv =====
// Shared types, widths and kind codes for the quadratic root solver.
package qrs_pkg;

  // Field widths
  localparam int CoefWidth = 16;
  localparam int FracBits  = 16;
  localparam int TolWidth  = 34;
  localparam int RootWidth = 34;

  // Derived widths
  localparam int MagWidth  = 2 * CoefWidth + 2;   // |b*b - 4ac|
  localparam int SqrtWidth = MagWidth / 2;         // floor(sqrt) width
  localparam int RemWidth  = SqrtWidth + 3;        // sqrt partial remainder
  localparam int NumWidth  = CoefWidth + FracBits + 3;  // signed numerator
  localparam int DenWidth  = CoefWidth + 2;        // signed denominator
  localparam int QuoWidth  = ((NumWidth > RootWidth) ? NumWidth : RootWidth) + 1;
  localparam int CmpWidth  = ((MagWidth > TolWidth) ? MagWidth : TolWidth);
  localparam int DivLat    = NumWidth + 2;         // divider pipeline depth

  // Buffer depths
  localparam int MidDepth  = 4;
  localparam int OutDepth  = 2;

  // Result count codes
  localparam logic [1:0] CountNone = 2'd0;
  localparam logic [1:0] CountOne  = 2'd1;
  localparam logic [1:0] CountTwo  = 2'd2;
  localparam logic [1:0] CountInf  = 2'd3;

  // Equation class decided by the front end
  typedef enum logic [2:0] {
    KIND_INF,
    KIND_NONE,
    KIND_LIN,
    KIND_ONE,
    KIND_TWO
  } kind_e;

  typedef struct packed {
    kind_e                        kind;
    logic signed [CoefWidth-1:0]  a;
    logic signed [CoefWidth-1:0]  b;
    logic signed [CoefWidth-1:0]  c;
  } item_t;

  typedef struct packed {
    item_t                 item;
    logic [MagWidth-1:0]   m;
  } mid_t;

  typedef struct packed {
    logic [1:0]                   count;
    logic signed [RootWidth-1:0]  r1;
    logic signed [RootWidth-1:0]  r2;
  } res_t;

endpackage

// ===== rtl/qrs_fifo.sv =====
// Small register queue used between pipeline sections.
module qrs_fifo
  import qrs_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0]     mem_q [Depth];
  logic [AddrWidth-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AddrWidth:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (AddrWidth+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AddrWidth'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AddrWidth'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the incoming entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/qrs_front.sv =====
// Front end: accept coefficients, form the discriminant and classify the equation.
module qrs_front
  import qrs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [CoefWidth-1:0] coef_quad_i,
  input  logic signed [CoefWidth-1:0] coef_lin_i,
  input  logic signed [CoefWidth-1:0] coef_const_i,
  input  logic [TolWidth-1:0]         tol_i,
  output logic                        mid_push_o,
  output mid_t                        mid_data_o,
  input  logic                        mid_full_i
);

  logic                           en;
  logic                           v1_q, v2_q;
  logic signed [CoefWidth-1:0]    a_q, b_q, c_q;
  logic [2*CoefWidth-1:0]         bsq_q, ac_q;
  logic                           acneg_q;
  logic [CoefWidth-1:0]           amag, bmag, cmag;
  logic [MagWidth-1:0]            q_w, p4_w, m_w;
  logic                           neg_w;
  kind_e                          kind_w;
  mid_t                           mid_q;

  // Hold both stages while the queue ahead is full
  assign en         = !(v2_q && mid_full_i);
  assign full_o     = !en;
  assign mid_push_o = v2_q && !mid_full_i;
  assign mid_data_o = mid_q;

  assign amag = coef_quad_i[CoefWidth-1]  ? CoefWidth'(-coef_quad_i)  : coef_quad_i;
  assign bmag = coef_lin_i[CoefWidth-1]   ? CoefWidth'(-coef_lin_i)   : coef_lin_i;
  assign cmag = coef_const_i[CoefWidth-1] ? CoefWidth'(-coef_const_i) : coef_const_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
    end
  end

  // Stage one: squares and products of magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= coef_quad_i;
      b_q     <= coef_lin_i;
      c_q     <= coef_const_i;
      bsq_q   <= bmag * bmag;
      ac_q    <= amag * cmag;
      acneg_q <= (coef_quad_i[CoefWidth-1] != coef_const_i[CoefWidth-1]) &&
                 (coef_const_i != '0);
    end
  end

  // Stage two: discriminant magnitude, its sign and the class
  always_comb begin
    q_w   = MagWidth'(bsq_q);
    p4_w  = {ac_q, 2'b00};
    neg_w = 1'b0;
    if (acneg_q) begin
      m_w = q_w + p4_w;
    end else if (q_w >= p4_w) begin
      m_w = q_w - p4_w;
    end else begin
      m_w   = p4_w - q_w;
      neg_w = 1'b1;
    end
    if (a_q == '0) begin
      if (b_q == '0) begin
        kind_w = (c_q == '0) ? KIND_INF : KIND_NONE;
      end else begin
        kind_w = KIND_LIN;
      end
    end else if (neg_w && (CmpWidth'(m_w) >= CmpWidth'(tol_i))) begin
      kind_w = KIND_NONE;
    end else if (CmpWidth'(m_w) < CmpWidth'(tol_i)) begin
      kind_w = KIND_ONE;
    end else begin
      kind_w = KIND_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_q.item.kind <= kind_w;
      mid_q.item.a    <= a_q;
      mid_q.item.b    <= b_q;
      mid_q.item.c    <= c_q;
      mid_q.m         <= m_w;
    end
  end

endmodule

// ===== rtl/qrs_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating and saturating.
module qrs_div
  import qrs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [NumWidth-1:0]  num_i,
  input  logic signed [DenWidth-1:0]  den_i,
  output logic signed [RootWidth-1:0] quo_o
);

  localparam logic [QuoWidth-1:0] PosMax =
    {{(QuoWidth-RootWidth+1){1'b0}}, {(RootWidth-1){1'b1}}};
  localparam logic [QuoWidth-1:0] NegMag =
    {{(QuoWidth-RootWidth){1'b0}}, 1'b1, {(RootWidth-1){1'b0}}};
  localparam logic [RootWidth-1:0] RootMin = {1'b1, {(RootWidth-1){1'b0}}};
  localparam logic [RootWidth-1:0] RootMax = {1'b0, {(RootWidth-1){1'b1}}};

  logic [NumWidth-1:0] nq_q   [NumWidth+1];
  logic [DenWidth-1:0] rem_q  [NumWidth+1];
  logic [DenWidth-1:0] dmag_q [NumWidth+1];
  logic                neg_q  [NumWidth+1];
  logic [QuoWidth-1:0] qx, qneg;
  logic [RootWidth-1:0] quo_q;

  // Stage zero: magnitudes and result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0]   <= num_i[NumWidth-1] ? NumWidth'(-num_i) : num_i;
      dmag_q[0] <= den_i[DenWidth-1] ? DenWidth'(-den_i) : den_i;
      rem_q[0]  <= '0;
      neg_q[0]  <= num_i[NumWidth-1] ^ den_i[DenWidth-1];
    end
  end

  // Restoring steps, most significant bit first
  for (genvar k = 1; k <= NumWidth; k++) begin : g_step
    logic [DenWidth:0] trial;
    logic              take;
    assign trial = {rem_q[k-1], nq_q[k-1][NumWidth-1]};
    assign take  = (trial >= {1'b0, dmag_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? DenWidth'(trial - {1'b0, dmag_q[k-1]}) : trial[DenWidth-1:0];
        nq_q[k]   <= {nq_q[k-1][NumWidth-2:0], take};
        dmag_q[k] <= dmag_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
  end

  // Apply sign and clamp to the root range
  assign qx   = QuoWidth'(nq_q[NumWidth]);
  assign qneg = -qx;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[NumWidth]) begin
        quo_q <= (qx > NegMag) ? RootMin : qneg[RootWidth-1:0];
      end else begin
        quo_q <= (qx > PosMax) ? RootMax : qx[RootWidth-1:0];
      end
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/qrs_back.sv =====
// Back end: pipelined square root, root numerators, dividers and result select.
module qrs_back
  import qrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  mid_t mid_data_i,
  input  logic mid_empty_i,
  output logic mid_pop_o,
  output logic res_push_o,
  output res_t res_o,
  input  logic res_full_i
);

  logic en;
  logic take;

  logic                 sv_q    [SqrtWidth];
  logic [RemWidth-1:0]  srem_q  [SqrtWidth];
  logic [SqrtWidth-1:0] sroot_q [SqrtWidth];
  logic [MagWidth-1:0]  srad_q  [SqrtWidth];
  item_t                spl_q   [SqrtWidth];

  logic                       fv_q;
  kind_e                      fkind_q;
  logic signed [NumWidth-1:0] fn1_q, fn2_q;
  logic signed [DenWidth-1:0] fden_q;
  logic signed [NumWidth-1:0] nb, ns, n1_w, n2_w;
  logic signed [DenWidth-1:0] den_w;
  item_t                      tail;

  logic  dv_q [DivLat];
  kind_e dk_q [DivLat];
  logic signed [RootWidth-1:0] quo1, quo2;

  // Stall everything while a finished result cannot be stored
  assign en         = !(dv_q[DivLat-1] && res_full_i);
  assign take       = en && !mid_empty_i;
  assign mid_pop_o  = take;
  assign res_push_o = dv_q[DivLat-1] && !res_full_i;

  // Square root, two radicand bits per stage
  for (genvar k = 0; k < SqrtWidth; k++) begin : g_sqrt
    logic                 v_in;
    logic [RemWidth-1:0]  rem_in, rem_sh, trial;
    logic [SqrtWidth-1:0] root_in;
    logic [MagWidth-1:0]  rad_in;
    item_t                pl_in;
    if (k == 0) begin : g_first
      assign v_in    = take;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = mid_data_i.m;
      assign pl_in   = mid_data_i.item;
    end else begin : g_next
      assign v_in    = sv_q[k-1];
      assign rem_in  = srem_q[k-1];
      assign root_in = sroot_q[k-1];
      assign rad_in  = srad_q[k-1];
      assign pl_in   = spl_q[k-1];
    end
    assign rem_sh = {rem_in[RemWidth-3:0], rad_in[MagWidth-1 -: 2]};
    assign trial  = {{(RemWidth-SqrtWidth-2){1'b0}}, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en) begin
        sv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_sh >= trial) begin
          srem_q[k]  <= rem_sh - trial;
          sroot_q[k] <= {root_in[SqrtWidth-2:0], 1'b1};
        end else begin
          srem_q[k]  <= rem_sh;
          sroot_q[k] <= {root_in[SqrtWidth-2:0], 1'b0};
        end
        srad_q[k] <= {rad_in[MagWidth-3:0], 2'b00};
        spl_q[k]  <= pl_in;
      end
    end
  end

  // Form numerators and the shared denominator
  assign tail = spl_q[SqrtWidth-1];
  assign nb   = NumWidth'(tail.b);
  assign ns   = NumWidth'({1'b0, sroot_q[SqrtWidth-1]});

  always_comb begin
    if (tail.kind == KIND_LIN) begin
      n1_w  = (-NumWidth'(tail.c)) <<< FracBits;
      den_w = DenWidth'(tail.b);
    end else begin
      n1_w  = (tail.kind == KIND_TWO) ? ((ns - nb) <<< FracBits) : ((-nb) <<< FracBits);
      den_w = DenWidth'(tail.a) <<< 1;
    end
    n2_w = (-nb - ns) <<< FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en) begin
      fv_q <= sv_q[SqrtWidth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fkind_q <= tail.kind;
      fn1_q   <= n1_w;
      fn2_q   <= n2_w;
      fden_q  <= den_w;
    end
  end

  qrs_div u_div_first (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (fn1_q),
    .den_i (fden_q),
    .quo_o (quo1)
  );

  qrs_div u_div_second (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (fn2_q),
    .den_i (fden_q),
    .quo_o (quo2)
  );

  // Carry the class alongside the dividers
  for (genvar k = 0; k < DivLat; k++) begin : g_kind
    logic  v_in;
    kind_e k_in;
    if (k == 0) begin : g_first
      assign v_in = fv_q;
      assign k_in = fkind_q;
    end else begin : g_next
      assign v_in = dv_q[k-1];
      assign k_in = dk_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dk_q[k] <= k_in;
      end
    end
  end

  // Select count and roots by class
  always_comb begin
    res_o.r1 = '0;
    res_o.r2 = '0;
    unique case (dk_q[DivLat-1])
      KIND_INF: begin
        res_o.count = CountInf;
      end
      KIND_LIN, KIND_ONE: begin
        res_o.count = CountOne;
        res_o.r1    = quo1;
      end
      KIND_TWO: begin
        res_o.count = CountTwo;
        res_o.r1    = quo1;
        res_o.r2    = quo2;
      end
      default: begin
        res_o.count = CountNone;
      end
    endcase
  end

endmodule

// ===== rtl/quadratic_root_solver_top.sv =====
// Top level of the quadratic root solver: front end, queues and back end.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | push / full          | coef_quad_i, coef_lin_i, coef_const_i
//  result   | empty / pop          | root_count_o, root_first_o, root_second_o
//  config   | cfg_we_i             | cfg_wdata_i (discriminant tolerance)
//
//  One coefficient set is taken per cycle while full is low; each result passes
//  through the 17-stage square root and the one-bit-per-stage dividers.
//  Reset clears all valid bits and sets the tolerance to one.
//  A full result queue stalls the back end; the short middle queue then fills
//  and full rises at the input.
module quadratic_root_solver_top
  import qrs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic signed [CoefWidth-1:0] coef_quad_i,
  input  logic signed [CoefWidth-1:0] coef_lin_i,
  input  logic signed [CoefWidth-1:0] coef_const_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [1:0]                  root_count_o,
  output logic signed [RootWidth-1:0] root_first_o,
  output logic signed [RootWidth-1:0] root_second_o,
  input  logic                        cfg_we_i,
  input  logic [TolWidth-1:0]         cfg_wdata_i
);

  logic [TolWidth-1:0] tol_q;
  logic mid_push, mid_full, mid_empty, mid_pop;
  mid_t mid_in, mid_out;
  logic res_push, res_full;
  res_t res_in, res_out;

  // Hold the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolWidth'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  qrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .coef_quad_i  (coef_quad_i),
    .coef_lin_i   (coef_lin_i),
    .coef_const_i (coef_const_i),
    .tol_i        (tol_q),
    .mid_push_o   (mid_push),
    .mid_data_o   (mid_in),
    .mid_full_i   (mid_full)
  );

  qrs_fifo #(
    .Width ($bits(mid_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_in),
    .pop_i   (mid_pop),
    .rdata_o (mid_out),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  qrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_data_i  (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  qrs_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_out),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign root_count_o  = res_out.count;
  assign root_first_o  = res_out.r1;
  assign root_second_o = res_out.r2;

  // Unused root fields must read zero
  a_unused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (root_count_o == CountNone || root_count_o == CountInf))
      |-> (root_first_o == '0 && root_second_o == '0))
    else $error("root field not zero for a no-root or infinite result");

  a_single_second_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && root_count_o == CountOne) |-> (root_second_o == '0))
    else $error("second root not zero for a single-root result");

  // A transaction pushed to the middle queue is never dropped
  a_mid_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_full |-> !mid_push)
    else $error("middle queue pushed while full");

endmodule

// ===== bench/qrs_checker.sv =====
// Checker for the quadratic root solver: predicts each result and compares it.
module qrs_checker
  import qrs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  logic                        full,
  input  logic signed [CoefWidth-1:0] coef_quad_i,
  input  logic signed [CoefWidth-1:0] coef_lin_i,
  input  logic signed [CoefWidth-1:0] coef_const_i,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [1:0]                  root_count_o,
  input  logic signed [RootWidth-1:0] root_first_o,
  input  logic signed [RootWidth-1:0] root_second_o,
  input  logic                        cfg_we_i,
  input  logic [TolWidth-1:0]         cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TolWidth-1:0] tolerance;
  res_t                expected_roots[$];

  assign pending_o = expected_roots.size();

  // Truncating division, saturated to the root width
  function automatic logic signed [RootWidth-1:0] scaled_quotient(longint num, longint den);
    longint q;
    longint hi_lim;
    hi_lim = (longint'(1) << (RootWidth - 1)) - 1;
    q = num / den;
    if (q > hi_lim) q = hi_lim;
    if (q < -hi_lim - 1) q = -hi_lim - 1;
    return q[RootWidth-1:0];
  endfunction

  // Floored square root of a non-negative discriminant
  function automatic longint floor_sqrt(longint m);
    longint r;
    longint cand;
    r = 0;
    for (int k = 17; k >= 0; k--) begin
      cand = r | (longint'(1) << k);
      if (cand * cand <= m) r = cand;
    end
    return r;
  endfunction

  function automatic res_t solve_roots(logic signed [CoefWidth-1:0] qa,
                                       logic signed [CoefWidth-1:0] qb,
                                       logic signed [CoefWidth-1:0] qc,
                                       logic [TolWidth-1:0] tol);
    res_t   r;
    longint a;
    longint b;
    longint c;
    longint disc;
    longint mag;
    longint t;
    longint s;
    a = qa;
    b = qb;
    c = qc;
    t = longint'(tol);
    r = '0;
    if (a == 0) begin
      if (b == 0) begin
        r.count = (c == 0) ? CountInf : CountNone;
      end else begin
        r.count = CountOne;
        r.r1 = scaled_quotient(-c * (longint'(1) << FracBits), b);
      end
    end else begin
      disc = b * b - 4 * a * c;
      mag = (disc < 0) ? -disc : disc;
      if (disc < 0 && mag >= t) begin
        r.count = CountNone;
      end else if (mag < t) begin
        r.count = CountOne;
        r.r1 = scaled_quotient(-b * (longint'(1) << FracBits), 2 * a);
      end else begin
        s = floor_sqrt(disc);
        r.count = CountTwo;
        r.r1 = scaled_quotient((-b + s) * (longint'(1) << FracBits), 2 * a);
        r.r2 = scaled_quotient((-b - s) * (longint'(1) << FracBits), 2 * a);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // Track the tolerance register and predict each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance <= TolWidth'(1);
    end else begin
      if (cfg_we_i) tolerance <= cfg_wdata_i;
      if (push && !full)
        expected_roots.push_back(solve_roots(coef_quad_i, coef_lin_i, coef_const_i,
                                             tolerance));
    end
  end

  // Compare each popped result with the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("result with no prediction waiting");
      end else begin
        want = expected_roots.pop_front();
        if (root_count_o !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", root_count_o, want.count));
        if (root_first_o !== want.r1)
          report_mismatch($sformatf("first root %0d, want %0d", root_first_o, want.r1));
        if (root_second_o !== want.r2)
          report_mismatch($sformatf("second root %0d, want %0d", root_second_o, want.r2));
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the quadratic root solver: stimulus, tolerance phases, verdict.
module tb;
  import qrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 80;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        push = 1'b0;
  logic                        full;
  logic signed [CoefWidth-1:0] coef_quad_i = '0;
  logic signed [CoefWidth-1:0] coef_lin_i = '0;
  logic signed [CoefWidth-1:0] coef_const_i = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [1:0]                  root_count_o;
  logic signed [RootWidth-1:0] root_first_o;
  logic signed [RootWidth-1:0] root_second_o;
  logic                        cfg_we_i = 1'b0;
  logic [TolWidth-1:0]         cfg_wdata_i = '0;
  int                          fail_count;
  int                          pending;
  bit                          steady;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  quadratic_root_solver_top u_dut (.*);

  qrs_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  // Mostly short gaps, a few long ones; none during a steady stretch
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one coefficient set and hold it until the front end accepts it
  task automatic send_coefs(int qa, int qb, int qc);
    int gap;
    push         <= 1'b1;
    coef_quad_i  <= qa[CoefWidth-1:0];
    coef_lin_i   <= qb[CoefWidth-1:0];
    coef_const_i <= qc[CoefWidth-1:0];
    do @(posedge clk_i); while (full);
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain the pipeline, then write the tolerance
  task automatic set_tolerance(logic [TolWidth-1:0] tol);
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= tol;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int rand_coef();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $signed($urandom_range(0, 65535)) - 32768;
    if (pick < 8) return $signed($urandom_range(0, 40)) - 20;
    if (pick < 9) return 0;
    return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
  endfunction

  // One random set; some are steered so the discriminant lands near zero
  task automatic send_random();
    int qa;
    int qb;
    int qc;
    int k;
    if ($urandom_range(0, 3) == 0) begin
      k  = $urandom_range(1, 180);
      qa = $urandom_range(1, 180);
      qc = k * k * qa / (qa * qa > 0 ? qa : 1);
      qa = ($urandom_range(0, 1) != 0) ? qa : -qa;
      qb = 2 * k * ((qa < 0) ? -qa : qa) + $signed($urandom_range(0, 6)) - 3;
      qc = k * k * qa;
      if (qc > 32767 || qc < -32768) qc = qa;
      if (qb > 32767) qb = 32767;
      if ($urandom_range(0, 1) != 0) qb = -qb;
    end else begin
      qa = rand_coef();
      qb = rand_coef();
      qc = rand_coef();
    end
    send_coefs(qa, qb, qc);
  endtask

  // Result side: bursts of pops and stalls
  initial begin
    @(posedge rst_ni);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (gap_len() > 0) begin
        pop <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [TolWidth-1:0] tolerances [7];
    tolerances = '{TolWidth'(0), TolWidth'(1), TolWidth'(64'h2_0000_0000),
                   {TolWidth{1'b1}}, TolWidth'(1000), TolWidth'(123457),
                   TolWidth'($urandom_range(2, 30))};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets under the reset tolerance
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 5);
    send_coefs(0, 3, -7);
    send_coefs(0, -32768, 32767);
    send_coefs(0, 1, -32768);
    send_coefs(1, 2, 1);
    send_coefs(1, 0, 1);
    send_coefs(1, -3, 2);
    send_coefs(-1, 0, 4);
    send_coefs(32767, 32767, 32767);
    send_coefs(-32768, -32768, -32768);
    send_coefs(-32768, 32767, 32767);
    send_coefs(1, -32768, -32768);
    send_coefs(1, 32767, 0);
    send_coefs(-1, -32768, 32767);
    send_coefs(4, 4, 1);
    send_coefs(2, 5, 3);

    // Random phases, one per tolerance setting
    foreach (tolerances[i]) begin
      set_tolerance(tolerances[i]);
      if (i == 0) begin
        send_coefs(1, 2, 1);
        send_coefs(-3, 6, -3);
      end
      for (int n = 0; n < 240; n++) begin
        if (n % 60 == 0) steady = ($urandom_range(0, 2) == 0);
        send_random();
      end
      steady = 1'b0;
    end

    // Drain and give the verdict
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #(12ns * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qrs_pkg.sv
rtl/qrs_fifo.sv
rtl/qrs_front.sv
rtl/qrs_div.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver_top.sv
bench/qrs_checker.sv
bench/tb.sv
